// File: src/pbld_pkg.sv
// Package for the partial body length decoder.
// Holds the phase and status codes, the header lead byte boundaries and the item and result types.
// No dependencies; every other file in src imports it.
package pbld_pkg;

	// Decoder phases.
	localparam logic [2:0] PH_LEAD   = 3'd0;
	localparam logic [2:0] PH_SECOND = 3'd1;
	localparam logic [2:0] PH_LONG   = 3'd2;
	localparam logic [2:0] PH_BODY   = 3'd3;
	localparam logic [2:0] PH_DONE   = 3'd4;
	localparam logic [2:0] PH_ERROR  = 3'd5;

	// Result status codes.
	localparam logic [1:0] ST_DATA      = 2'd0;
	localparam logic [1:0] ST_END       = 2'd1;
	localparam logic [1:0] ST_NO_LENGTH = 2'd2;
	localparam logic [1:0] ST_TRUNCATED = 2'd3;

	// Header lead byte boundaries.
	localparam logic [7:0] LEAD_TWO_BYTE  = 8'd192;
	localparam logic [7:0] LEAD_PARTIAL   = 8'd224;
	localparam logic [7:0] LEAD_FIVE_BYTE = 8'd255;
	localparam logic [31:0] TWO_BYTE_BIAS = 32'd192;

	typedef struct packed {
		logic [7:0] data;
		logic       ended;
	} pbld_item_t;

	typedef struct packed {
		logic [7:0] data;
		logic [1:0] status;
		logic       last;
	} pbld_res_t;

endpackage

// File: src/pbld_ctrl.sv
// Header parser and body counter of the partial body length decoder.
// Holds the framing state and decides the result for the item in stage 1.
// Depends on pbld_pkg.
module pbld_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  pbld_pkg::pbld_item_t item_s1,
	input  logic                 fire,
	output logic                 emit,
	output pbld_pkg::pbld_res_t  res
);
	import pbld_pkg::*;

	logic [2:0]  phase_q, phase_d;
	logic [31:0] rem_q, rem_d;
	logic        fin_q, fin_d;
	logic [1:0]  lbl_q, lbl_d;
	logic [7:0]  c;
	logic [31:0] rem_m1;
	logic [31:0] long_rem;

	assign c        = item_s1.data;
	assign rem_m1   = rem_q - 32'd1;
	assign long_rem = {rem_q[23:0], c};

	always_comb begin
		phase_d = phase_q;
		rem_d   = rem_q;
		fin_d   = fin_q;
		lbl_d   = lbl_q;
		emit    = 1'b0;
		res     = '{data: 8'd0, status: ST_DATA, last: 1'b0};
		if (phase_q <= PH_BODY) begin
			if (item_s1.ended) begin
				phase_d = PH_ERROR;
				emit    = 1'b1;
				res.status = (phase_q == PH_BODY && rem_q != 32'd0) ? ST_TRUNCATED
					: ST_NO_LENGTH;
			end else begin
				unique case (phase_q)
					PH_LEAD: begin
						if (c < LEAD_TWO_BYTE) begin
							rem_d = {24'd0, c};
							fin_d = 1'b1;
							if (c == 8'd0) begin
								phase_d    = PH_DONE;
								emit       = 1'b1;
								res.status = ST_END;
							end else begin
								phase_d = PH_BODY;
							end
						end else if (c < LEAD_PARTIAL) begin
							// (lead - 192) * 256; lead bits 4:0 are the high part.
							rem_d   = {19'd0, c[4:0], 8'd0};
							phase_d = PH_SECOND;
						end else if (c == LEAD_FIVE_BYTE) begin
							rem_d   = 32'd0;
							lbl_d   = 2'd3;
							phase_d = PH_LONG;
						end else begin
							rem_d   = 32'd1 << c[4:0];
							fin_d   = 1'b0;
							phase_d = PH_BODY;
						end
					end
					PH_SECOND: begin
						rem_d   = rem_q + {24'd0, c} + TWO_BYTE_BIAS;
						fin_d   = 1'b1;
						phase_d = PH_BODY;
					end
					PH_LONG: begin
						rem_d = long_rem;
						if (lbl_q != 2'd0) begin
							lbl_d = lbl_q - 2'd1;
						end else begin
							fin_d = 1'b1;
							if (long_rem == 32'd0) begin
								phase_d    = PH_DONE;
								emit       = 1'b1;
								res.status = ST_END;
							end else begin
								phase_d = PH_BODY;
							end
						end
					end
					PH_BODY: begin
						if (rem_q == 32'd0) begin
							phase_d = PH_LEAD;
						end else begin
							rem_d    = rem_m1;
							emit     = 1'b1;
							res.data = c;
							if (rem_m1 == 32'd0) begin
								if (fin_q) begin
									phase_d  = PH_DONE;
									res.last = 1'b1;
								end else begin
									phase_d = PH_LEAD;
								end
							end
						end
					end
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_LEAD;
			rem_q   <= 32'd0;
			fin_q   <= 1'b0;
			lbl_q   <= 2'd0;
		end else if (fire) begin
			phase_q <= phase_d;
			rem_q   <= rem_d;
			fin_q   <= fin_d;
			lbl_q   <= lbl_d;
		end
	end

	// Any end or error result leaves the decoder in a terminal phase.
	a_terminal_after_status: assert property (@(posedge clk) disable iff (!arst_n)
		fire && emit && res.status != ST_DATA |=> phase_q == PH_DONE || phase_q == PH_ERROR)
		else $error("non-data result did not stop the decoder");

	// The marked final byte ends the stream.
	a_done_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		fire && emit && res.last |=> phase_q == PH_DONE)
		else $error("last byte did not move the decoder to done");

	// Terminal phases are sticky.
	a_terminal_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_DONE || phase_q == PH_ERROR |=> $stable(phase_q))
		else $error("terminal phase left before reset");

endmodule

// File: src/pbld_outreg.sv
// Result register of the partial body length decoder.
// Holds one result until the output transfer completes.
// Depends on pbld_pkg.
module pbld_outreg (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  pbld_pkg::pbld_res_t res,
	input  logic                out_ready,
	output logic                out_valid,
	output logic                slot_free,
	output pbld_pkg::pbld_res_t res_q
);
	import pbld_pkg::*;

	logic valid_q;

	assign slot_free = !valid_q || out_ready;
	assign out_valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (slot_free) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

endmodule

// File: src/partial_body_length_decoder_top.sv
// Partial body length decoder, top level. Depends on pbld_pkg, pbld_ctrl, pbld_outreg.
// Pipeline: two register stages, the input register and the result register. A result
// is decided while its byte sits in the input register, is then held in the result
// register and leaves from there once out_ready is high.
// Throughput: one input byte per cycle; header bytes produce no result. A byte that
// produces a result waits in the input register while a stalled result occupies the
// result register, and the input stalls with it.
// Reset: arst_n clears all valid flags and returns the decoder to expecting a lead byte.
module partial_body_length_decoder_top (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	input  logic       in_end,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic [1:0] status,
	output logic       last
);
	import pbld_pkg::*;

	// Stage 1 holds the accepted input transfer while its result is decided.
	pbld_item_t item_s1;
	logic       valid_s1;
	logic       emit;
	logic       fire;
	logic       slot_free;
	pbld_res_t  res;
	pbld_res_t  res_q;

	// The stage 1 item retires when it either produces nothing or the
	// result register can take its result. Header bytes retire without
	// waiting on the output side, so the input keeps moving.
	assign fire     = valid_s1 && (!emit || slot_free);
	assign in_ready = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= '{data: in_byte, ended: in_end};
		end
	end

	// Framing state and the per-byte decision.
	pbld_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.item_s1 (item_s1),
		.fire    (fire),
		.emit    (emit),
		.res     (res)
	);

	// Result register; it accepts a new result in the cycle the old one leaves.
	pbld_outreg u_outreg (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (fire && emit),
		.res       (res),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.slot_free (slot_free),
		.res_q     (res_q)
	);

	assign out_byte = res_q.data;
	assign status   = res_q.status;
	assign last     = res_q.last;

	// Only a payload byte can carry the final-byte mark.
	a_last_is_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last |-> status == ST_DATA)
		else $error("last mark on a non-data result");

	// A result is never loaded into a full, stalled result register.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !(fire && emit))
		else $error("result register overwritten while stalled");

endmodule

// File: dv/partial_body_length_decoder_top_test.sv
// Self-checking testbench for the partial body length decoder top level.
// Depends on pbld_pkg and partial_body_length_decoder_top; the expected results come
// from a decoder predictor that lives in this file.
module partial_body_length_decoder_top_test;
	timeunit 1ns;
	timeprecision 1ps;
	import pbld_pkg::*;

	localparam int RUN_ITEMS   = 1500;
	localparam int CYCLE_LIMIT = 600000;

	// The decoder accepts exactly one framed stream per reset, and reset is applied
	// only once. So every run carries one long stream of partial chunks, and the
	// seed picks the way that stream is closed.
	typedef enum int {
		END_ONE_BYTE,
		END_ZERO_ONE_BYTE,
		END_TWO_BYTE,
		END_FIVE_BYTE,
		END_ZERO_FIVE_BYTE,
		CUT_AT_LEAD,
		CUT_AT_SECOND,
		CUT_IN_LONG_LENGTH,
		CUT_IN_BODY
	} stream_end_e;

	logic       clk       = 1'b0;
	logic       arst_n    = 1'b0;
	logic       in_valid  = 1'b0;
	logic       in_ready;
	logic [7:0] in_byte   = 8'd0;
	logic       in_end    = 1'b0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [7:0] out_byte;
	logic [1:0] status;
	logic       last;

	// Predictor state. The initial values are the decoder state after reset.
	logic [2:0]  dec_phase    = PH_LEAD;
	logic [31:0] dec_left     = 32'd0;
	logic        dec_final    = 1'b0;
	logic [1:0]  dec_len_left = 2'd0;

	// Results still due from the decoder, oldest first.
	pbld_res_t expected_results[$];

	// A gap or a stall starts with a chance of one in the given number.
	// Zero turns that side's idling off.
	int idle_odds  = 0;
	int stall_odds = 0;

	int bytes_sent      = 0;
	int chunks_sent     = 0;
	int results_checked = 0;
	int failures        = 0;
	int cycle_count     = 0;
	stream_end_e end_case = END_ONE_BYTE;

	partial_body_length_decoder_top uut (.*);

	initial begin
		forever #2 clk = ~clk;
	end

	// The watchdog ends a run that hangs. The limit is far above the slowest
	// correct run, which is about 1700 bytes with full idling and then a
	// final chunk of 8383 bytes with no idling.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles with %0d results still due.",
				cycle_count, expected_results.size());
			$display("partial_body_length_decoder_top verification failed");
			$finish;
		end
	end

	// Decoder predictor. It consumes one accepted input and returns 1 when
	// that input yields a result, which is then placed in res.
	function automatic bit decode_byte(input logic [7:0] b, input logic ended,
			output pbld_res_t res);
		res = '0;
		// Once the stream has ended or failed, every input is dropped.
		if (dec_phase > PH_BODY)
			return 1'b0;
		// An exhausted source is a truncation inside a body, and a missing
		// length byte anywhere else.
		if (ended) begin
			res.status = (dec_phase == PH_BODY && dec_left != 32'd0) ? ST_TRUNCATED
				: ST_NO_LENGTH;
			dec_phase = PH_ERROR;
			return 1'b1;
		end
		case (dec_phase)
		PH_LEAD: begin
			if (b < LEAD_TWO_BYTE) begin
				dec_left  = {24'd0, b};
				dec_final = 1'b1;
				if (b == 8'd0) begin
					dec_phase  = PH_DONE;
					res.status = ST_END;
					return 1'b1;
				end
				dec_phase = PH_BODY;
			end else if (b < LEAD_PARTIAL) begin
				dec_left  = {16'd0, 8'(b - LEAD_TWO_BYTE), 8'd0};
				dec_phase = PH_SECOND;
			end else if (b == LEAD_FIVE_BYTE) begin
				dec_left     = 32'd0;
				dec_len_left = 2'd3;
				dec_phase    = PH_LONG;
			end else begin
				dec_left  = 32'd1 << b[4:0];
				dec_final = 1'b0;
				dec_phase = PH_BODY;
			end
			return 1'b0;
		end
		PH_SECOND: begin
			dec_left  = dec_left + b + TWO_BYTE_BIAS;
			dec_final = 1'b1;
			dec_phase = PH_BODY;
			return 1'b0;
		end
		PH_LONG: begin
			dec_left = {dec_left[23:0], b};
			if (dec_len_left != 2'd0) begin
				dec_len_left = dec_len_left - 2'd1;
				return 1'b0;
			end
			dec_final = 1'b1;
			if (dec_left == 32'd0) begin
				dec_phase  = PH_DONE;
				res.status = ST_END;
				return 1'b1;
			end
			dec_phase = PH_BODY;
			return 1'b0;
		end
		default: begin
			// An empty body cannot be entered; a header would follow.
			if (dec_left == 32'd0) begin
				dec_phase = PH_LEAD;
				return 1'b0;
			end
			dec_left   = dec_left - 32'd1;
			res.data   = b;
			res.status = ST_DATA;
			if (dec_left == 32'd0) begin
				if (dec_final) begin
					dec_phase = PH_DONE;
					res.last  = 1'b1;
				end else begin
					dec_phase = PH_LEAD;
				end
			end
			return 1'b1;
		end
		endcase
	endfunction

	// Body bytes lean on the extremes now and then.
	function automatic logic [7:0] random_byte();
		case ($urandom_range(0, 7))
		0: return 8'h00;
		1: return 8'hFF;
		default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// Sends one input transfer and, once it is accepted, records what it should
	// cause. Valid stays high from one transfer to the next unless a gap is taken.
	task automatic send_item(input logic [7:0] b, input logic ended);
		pbld_res_t res;
		if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_byte  <= b;
		in_end   <= ended;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		if (decode_byte(b, ended, res))
			expected_results.push_back(res);
		bytes_sent++;
	endtask

	task automatic send_chunk_body(input longint count);
		for (longint i = 0; i < count; i++)
			send_item(random_byte(), 1'b0);
	endtask

	// Five-byte header: the lead byte, then the length most significant byte first.
	task automatic send_long_length(input logic [31:0] len);
		send_item(LEAD_FIVE_BYTE, 1'b0);
		for (int i = 3; i >= 0; i--)
			send_item(len[8 * i +: 8], 1'b0);
	endtask

	task automatic drain_results();
		while (expected_results.size() != 0)
			@(posedge clk);
		// Header bytes yield nothing, so let the two-stage pipeline empty out.
		repeat (10) @(posedge clk);
	endtask

	// The receiver stalls in bursts whenever stall_odds allows it.
	initial begin
		forever begin
			@(posedge clk);
			if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 13)) @(posedge clk);
			end
			out_ready <= 1'b1;
		end
	end

	// Every accepted result is compared with the oldest expectation.
	always @(posedge clk) begin : check_results
		pbld_res_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_results.size() == 0) begin
				failures++;
				$display("%0t: result transfer with none expected: byte=%02h status=%0d last=%0b",
					$time, out_byte, status, last);
			end else begin
				want = expected_results.pop_front();
				if (out_byte !== want.data) begin
					failures++;
					$display("%0t: out_byte expected %02h, actual %02h", $time, want.data, out_byte);
				end
				if (status !== want.status) begin
					failures++;
					$display("%0t: status expected %0d, actual %0d", $time, want.status, status);
				end
				if (last !== want.last) begin
					failures++;
					$display("%0t: last expected %0b, actual %0b", $time, want.last, last);
				end
				results_checked++;
			end
		end
	end

	// Partial chunks of one, two, four and eight bytes, with body bytes at the
	// extremes and in alternating bit patterns.
	task automatic test_directed_partial_chunks();
		logic [7:0] pattern [15];
		int k;
		pattern = '{8'h00, 8'hFF, 8'h80, 8'h01, 8'h7F, 8'hFE, 8'hAA,
			8'hFF, 8'h00, 8'h55, 8'hAA, 8'h0F, 8'hF0, 8'h81, 8'h7E};
		k = 0;
		idle_odds  = 3;
		stall_odds = 3;
		for (int e = 0; e < 4; e++) begin
			send_item(8'(LEAD_PARTIAL + e), 1'b0);
			for (int i = 0; i < (1 << e); i++) begin
				send_item(pattern[k], 1'b0);
				k++;
			end
			chunks_sent++;
		end
	endtask

	// A long run of partial chunks with random sizes and contents. Both sides
	// change their idling every forty chunks, sometimes to none at all.
	task automatic test_random_partial_chunks();
		int exponent;
		while (bytes_sent < RUN_ITEMS) begin
			if (chunks_sent % 40 == 0) begin
				case ($urandom_range(0, 3))
				0: idle_odds = 0;
				1: idle_odds = 2;
				2: idle_odds = 5;
				default: idle_odds = 16;
				endcase
				case ($urandom_range(0, 3))
				0: stall_odds = 0;
				1: stall_odds = 2;
				2: stall_odds = 5;
				default: stall_odds = 16;
				endcase
			end
			exponent = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 7)
				: $urandom_range(0, 4);
			send_item(8'(LEAD_PARTIAL + exponent), 1'b0);
			send_chunk_body(longint'(1) << exponent);
			chunks_sent++;
		end
	endtask

	// Closes the stream in one of the ways the decoder knows: a final chunk in
	// each header form, a final length of zero, or the source running out at a
	// header byte or in a body. No idling from here on.
	task automatic test_stream_end();
		logic [7:0]  lead;
		logic [7:0]  second;
		logic [31:0] long_len;
		longint      body_len;
		int          cut;
		idle_odds  = 0;
		stall_odds = 0;
		end_case = stream_end_e'($urandom_range(0, 8));
		case (end_case)
		END_ONE_BYTE: begin
			lead = ($urandom_range(0, 2) == 0) ? 8'd191 : 8'($urandom_range(1, 191));
			send_item(lead, 1'b0);
			send_chunk_body(lead);
		end
		END_ZERO_ONE_BYTE: send_item(8'd0, 1'b0);
		END_TWO_BYTE: begin
			// Now and then the largest two-byte length, 8383 bytes.
			if ($urandom_range(0, 3) == 0) begin
				lead   = LEAD_PARTIAL - 8'd1;
				second = 8'hFF;
			end else begin
				lead   = 8'(LEAD_TWO_BYTE + $urandom_range(0, 1));
				second = random_byte();
			end
			send_item(lead, 1'b0);
			send_item(second, 1'b0);
			send_chunk_body((lead - LEAD_TWO_BYTE) * 256 + second + TWO_BYTE_BIAS);
		end
		END_FIVE_BYTE: begin
			long_len = ($urandom_range(0, 3) == 0) ? 32'd1 : 32'($urandom_range(1, 600));
			send_long_length(long_len);
			send_chunk_body(long_len);
		end
		END_ZERO_FIVE_BYTE: send_long_length(32'd0);
		CUT_AT_LEAD: send_item(random_byte(), 1'b1);
		CUT_AT_SECOND: begin
			send_item(8'($urandom_range(192, 223)), 1'b0);
			send_item(random_byte(), 1'b1);
		end
		CUT_IN_LONG_LENGTH: begin
			// The source may run out before any of the four length bytes.
			send_item(LEAD_FIVE_BYTE, 1'b0);
			repeat ($urandom_range(0, 3))
				send_item(random_byte(), 1'b0);
			send_item(random_byte(), 1'b1);
		end
		default: begin
			// Start a chunk of any kind, sometimes huge, and cut it short.
			case ($urandom_range(0, 3))
			0: begin
				lead = 8'($urandom_range(1, 191));
				send_item(lead, 1'b0);
				body_len = lead;
			end
			1: begin
				lead   = 8'($urandom_range(192, 223));
				second = random_byte();
				send_item(lead, 1'b0);
				send_item(second, 1'b0);
				body_len = (lead - LEAD_TWO_BYTE) * 256 + second + TWO_BYTE_BIAS;
			end
			2: begin
				long_len = ($urandom_range(0, 1) == 0) ? 32'hFFFF_FFFF : $urandom();
				if (long_len == 32'd0)
					long_len = 32'd1;
				send_long_length(long_len);
				body_len = long_len;
			end
			default: begin
				lead = 8'($urandom_range(224, 254));
				send_item(lead, 1'b0);
				body_len = longint'(1) << lead[4:0];
			end
			endcase
			cut = $urandom_range(0, (body_len > 300) ? 300 : int'(body_len - 1));
			send_chunk_body(cut);
			send_item(random_byte(), 1'b1);
		end
		endcase
		in_valid <= 1'b0;
		drain_results();
	endtask

	// After the end or an error the decoder must drop everything, exhausted
	// source indications included.
	task automatic test_input_ignored_after_end();
		repeat (30)
			send_item(random_byte(), 1'($urandom_range(0, 1)));
		in_valid <= 1'b0;
		drain_results();
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		test_directed_partial_chunks();
		test_random_partial_chunks();
		test_stream_end();
		test_input_ignored_after_end();
		$display("Sent %0d input transfers in %0d partial chunks; checked %0d result transfers.",
			bytes_sent, chunks_sent, results_checked);
		$display("Stream closed by case %s, then trailing input was shown to be dropped.",
			end_case.name());
		if (failures == 0) begin
			$display("partial_body_length_decoder_top verification clean");
		end else begin
			$display("%0d mismatches found.", failures);
			$display("partial_body_length_decoder_top verification failed");
		end
		$finish;
	end

endmodule
